/* rtl/core/lpc_pkg.sv */
`default_nettype none
package lpc_pkg;

  // Table and frame geometry
  localparam int unsigned PortCount    = 26;
  localparam int unsigned FrameBytes   = 666;
  localparam int unsigned SenderOffset = 400;
  localparam int unsigned HeaderBytes  = 14;

  localparam int unsigned PosW  = $clog2(FrameBytes + 1);
  localparam int unsigned IdxW  = (PortCount > 1) ? $clog2(PortCount) : 1;
  localparam int unsigned PortW = 5;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] FillByte   = 8'hBE;
  localparam logic [ByteW-1:0] EmptyEntry = 8'hFF;

  // Depth of the request queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    FuncByte = 1'b0,
    FuncRead = 1'b1
  } func_e;

  // Classified request from the front to the back
  typedef struct packed {
    func_e            func;
    logic             frame_ok;
    logic [ByteW-1:0] sender;
    logic [PortW-1:0] recv_port;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic             probe_valid;
    logic [ByteW-1:0] sender_port;
    logic [ByteW-1:0] paired_port;
    logic             newly_recorded;
    logic             port_out_of_range;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/lpc_front.sv */
`default_nettype none
module lpc_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       accept_i,
  input  wire                       func_i,
  input  wire [lpc_pkg::PortW-1:0]  port_i,
  input  wire [lpc_pkg::ByteW-1:0]  data_byte_i,
  input  wire                       frame_end_i,
  output logic                      cmd_valid_o,
  output lpc_pkg::cmd_t             cmd_o
);
  import lpc_pkg::*;

  localparam logic [PosW-1:0] FrameLen  = PosW'(FrameBytes);
  localparam logic [PosW-1:0] SenderPos = PosW'(SenderOffset);
  localparam logic [PosW-1:0] SparePos  = PosW'(SenderOffset + 1);
  localparam logic [PosW-1:0] HeaderLen = PosW'(HeaderBytes);

  logic [PosW-1:0]  pos_q, pos_d, pos_n;
  logic             ok_q, ok_d, ok_n;
  logic [ByteW-1:0] snd_q, snd_d, snd_n;
  logic             is_byte;

  assign is_byte = accept_i && (func_e'(func_i) == FuncByte);

  // Advance the frame state by one byte
  always_comb begin
    pos_n = pos_q;
    ok_n  = ok_q;
    snd_n = snd_q;
    if (is_byte && (pos_q < FrameLen)) begin
      if (pos_q == SenderPos) begin
        snd_n = data_byte_i;
      end else if ((pos_q >= HeaderLen) && (pos_q != SparePos) &&
                   (data_byte_i != FillByte)) begin
        ok_n = 1'b0;
      end
      pos_n = pos_q + PosW'(1);
    end
    pos_d = pos_n;
    ok_d  = ok_n;
    snd_d = snd_n;
    // Drop the frame state once its last byte is in
    if (is_byte && frame_end_i) begin
      pos_d = '0;
      ok_d  = 1'b1;
      snd_d = '0;
    end
  end

  // Classify: reads and frame ends become requests for the back
  always_comb begin
    cmd_valid_o     = accept_i && ((func_e'(func_i) == FuncRead) || frame_end_i);
    cmd_o.func      = func_e'(func_i);
    cmd_o.recv_port = port_i;
    if (func_e'(func_i) == FuncRead) begin
      cmd_o.frame_ok = 1'b0;
      cmd_o.sender   = ByteW'(port_i);
    end else begin
      cmd_o.frame_ok = ok_n && (pos_n >= FrameLen);
      cmd_o.sender   = snd_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ok_q  <= 1'b1;
      snd_q <= '0;
    end else begin
      pos_q <= pos_d;
      ok_q  <= ok_d;
      snd_q <= snd_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lpc_fifo.sv */
`default_nettype none
module lpc_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_i,
  input  lpc_pkg::cmd_t  wr_data_i,
  input  wire            rd_i,
  output logic           full_o,
  output logic           avail_o,
  output lpc_pkg::cmd_t  rd_data_o
);
  import lpc_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign avail_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && avail_o;

  // Hold requests in arrival order
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= wp_q + QPtrW'(1);
      end
      if (do_rd) begin
        rp_q <= rp_q + QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lpc_back.sv */
`default_nettype none
module lpc_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cmd_avail_i,
  input  lpc_pkg::cmd_t  cmd_i,
  output logic           cmd_take_o,
  input  wire            pop_i,
  output logic           res_valid_o,
  output lpc_pkg::res_t  res_o
);
  import lpc_pkg::*;

  // Pair table: one valid bit and a receiving port per entry
  logic [PortCount-1:0] vld_q;
  logic [PortW-1:0]     entry_q [PortCount];

  logic             out_valid_q;
  res_t             res_q, res_d;
  logic [IdxW-1:0]  idx;
  logic             oor, fresh;

  assign cmd_take_o  = cmd_avail_i && (!out_valid_q || pop_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign oor   = (cmd_i.sender >= ByteW'(PortCount));
  assign idx   = cmd_i.sender[IdxW-1:0];
  assign fresh = (cmd_i.func == FuncByte) && cmd_i.frame_ok && !oor && !vld_q[idx];

  // Look up the sender and decide whether to record it
  always_comb begin
    res_d.probe_valid       = (cmd_i.func == FuncByte) && cmd_i.frame_ok;
    res_d.sender_port       = cmd_i.sender;
    res_d.newly_recorded    = fresh;
    res_d.port_out_of_range = oor;
    if (oor) begin
      res_d.paired_port = EmptyEntry;
    end else if (fresh) begin
      res_d.paired_port = ByteW'(cmd_i.recv_port);
    end else if (vld_q[idx]) begin
      res_d.paired_port = ByteW'(entry_q[idx]);
    end else begin
      res_d.paired_port = EmptyEntry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      res_q <= res_d;
    end
    if (cmd_take_o && fresh) begin
      entry_q[idx] <= cmd_i.recv_port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_take_o && fresh) begin
        vld_q[idx] <= 1'b1;
      end
      if (cmd_take_o) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/loopback_probe_checker.sv */
`default_nettype none
// Loopback probe checker.
// Input queue side: drive func_i, port_i, data_byte_i, frame_end_i with push;
// a request is taken on a clock edge where push is high and full is low.
// Frame bytes (func_i = 0) arrive in order; the last byte of a frame carries
// frame_end_i and yields one result. A table read (func_i = 1) yields one
// result at once. Other bytes yield nothing.
// Result queue side: while empty is low the oldest result sits on the
// *_o ports; it is taken on an edge where pop is high.
// A request taken at an edge is written into the request queue; the table
// lookup then loads the output register when the back end takes the request
// from the queue.
// Throughput: one request per cycle while full is low, set by the table lookup
// and update in the back end, which stalls while its unpopped result is held.
// Reset clears the frame state, empties both queues and marks every pair
// table entry empty (reads return 255).
// When pop is held low the output register holds its result, the request
// queue fills and full rises after four more result-producing requests.
module loopback_probe_checker (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push,
  output logic                     full,
  input  wire                      func_i,
  input  wire [lpc_pkg::PortW-1:0] port_i,
  input  wire [lpc_pkg::ByteW-1:0] data_byte_i,
  input  wire                      frame_end_i,
  output logic                     empty,
  input  wire                      pop,
  output logic                     probe_valid_o,
  output logic [lpc_pkg::ByteW-1:0] sender_port_o,
  output logic [lpc_pkg::ByteW-1:0] paired_port_o,
  output logic                     newly_recorded_o,
  output logic                     port_out_of_range_o
);
  import lpc_pkg::*;

  logic accept;
  logic cmd_valid, q_avail, q_take, res_valid;
  cmd_t cmd_in, cmd_out;
  res_t res;

  assign accept = push && !full;

  lpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .port_i      (port_i),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  lpc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd_in),
    .rd_i      (q_take),
    .full_o    (full),
    .avail_o   (q_avail),
    .rd_data_o (cmd_out)
  );

  lpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (q_avail),
    .cmd_i       (cmd_out),
    .cmd_take_o  (q_take),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Drive the result ports
  assign empty               = !res_valid;
  assign probe_valid_o       = res.probe_valid;
  assign sender_port_o       = res.sender_port;
  assign paired_port_o       = res.paired_port;
  assign newly_recorded_o    = res.newly_recorded;
  assign port_out_of_range_o = res.port_out_of_range;

endmodule
`default_nettype wire

/* bench/tb_loopback_probe_checker.sv */
`timescale 1ns / 1ps
module tb_loopback_probe_checker;
  import lpc_pkg::*;

  typedef struct {
    func_e            func;
    logic [PortW-1:0] port;
    logic [ByteW-1:0] data;
    logic             eof;
    int               idle;
    bit               drain;
  } probe_req_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic             func_i = 1'b0;
  logic [PortW-1:0] port_i = '0;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             frame_end_i = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic             probe_valid_o;
  logic [ByteW-1:0] sender_port_o;
  logic [ByteW-1:0] paired_port_o;
  logic             newly_recorded_o;
  logic             port_out_of_range_o;

  // Requests waiting to be offered, and verdicts waiting to come out
  probe_req_t queued_requests[$];
  res_t       pending_verdicts[$];

  // Own copy of the frame state and the pair table
  logic [PosW-1:0]  frame_pos = '0;
  logic             frame_clean = 1'b1;
  logic [ByteW-1:0] frame_sender = '0;
  logic [ByteW-1:0] pair_map [PortCount];

  int n_built = 0;
  int n_taken = 0;
  int n_seen = 0;
  int n_fail = 0;
  int burst_at = 0;
  logic rx_hold = 1'b0;

  // Driver-local state
  probe_req_t next_req;
  bit         have_next = 1'b0;
  int         idle_left = 0;
  int         stall_left = 0;

  loopback_probe_checker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .func_i             (func_i),
    .port_i             (port_i),
    .data_byte_i        (data_byte_i),
    .frame_end_i        (frame_end_i),
    .empty              (empty),
    .pop                (pop),
    .probe_valid_o      (probe_valid_o),
    .sender_port_o      (sender_port_o),
    .paired_port_o      (paired_port_o),
    .newly_recorded_o   (newly_recorded_o),
    .port_out_of_range_o(port_out_of_range_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Idle cycles per request: none, uniform, or an occasional long gap
  function automatic int draw_idle(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pair_entry(input logic [ByteW-1:0] idx);
    return (idx < PortCount) ? pair_map[idx[IdxW-1:0]] : EmptyEntry;
  endfunction

  // Advance the frame state by one request and queue any verdict it yields
  function automatic void apply_probe_request(input probe_req_t r);
    res_t v;
    logic ok;
    logic oor;
    if (r.func == FuncRead) begin
      v.probe_valid       = 1'b0;
      v.sender_port       = {3'b000, r.port};
      v.paired_port       = pair_entry({3'b000, r.port});
      v.newly_recorded    = 1'b0;
      v.port_out_of_range = (r.port >= PortCount);
      pending_verdicts.push_back(v);
    end else begin
      if (frame_pos < FrameBytes) begin
        if (frame_pos == SenderOffset)
          frame_sender = r.data;
        else if (frame_pos >= HeaderBytes && frame_pos != SenderOffset + 1 &&
                 r.data != FillByte)
          frame_clean = 1'b0;
        frame_pos = frame_pos + 1'b1;
      end
      if (r.eof) begin
        ok  = frame_clean && (frame_pos >= FrameBytes);
        oor = (frame_sender >= PortCount);
        v.newly_recorded = ok && !oor && (pair_entry(frame_sender) == EmptyEntry);
        if (v.newly_recorded)
          pair_map[frame_sender[IdxW-1:0]] = {3'b000, r.port};
        v.probe_valid       = ok;
        v.sender_port       = frame_sender;
        v.paired_port       = pair_entry(frame_sender);
        v.port_out_of_range = oor;
        pending_verdicts.push_back(v);
        frame_pos    = '0;
        frame_clean  = 1'b1;
        frame_sender = '0;
      end
    end
  endfunction

  task automatic check_field(input string what, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= 40)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  task automatic add_req(input func_e func, input logic [PortW-1:0] port,
                         input logic [ByteW-1:0] data, input logic eof,
                         input int idle, input bit drain);
    probe_req_t r;
    r.func  = func;
    r.port  = port;
    r.data  = data;
    r.eof   = eof;
    r.idle  = idle;
    r.drain = drain;
    queued_requests.push_back(r);
    n_built++;
  endtask

  // Queue one table read at a random index
  task automatic add_read(input int idle);
    add_req(FuncRead, PortW'($urandom_range(0, 31)), ByteW'($urandom), 1'($urandom),
            idle, 1'b0);
  endtask

  // Queue one frame; the receiving port rides on the last byte
  task automatic queue_frame(input int len, input logic [ByteW-1:0] sender,
                             input int bad_pos, input logic [PortW-1:0] rx_port,
                             input int mode, input bit drain);
    logic [ByteW-1:0] b;
    for (int i = 0; i < len; i++) begin
      if (i < HeaderBytes || i >= FrameBytes || i == SenderOffset + 1)
        b = ByteW'($urandom);
      else if (i == SenderOffset)
        b = sender;
      else if (i == bad_pos) begin
        b = ByteW'($urandom);
        if (b == FillByte)
          b = ~b;
      end else
        b = FillByte;
      add_req(FuncByte, (i == len - 1) ? rx_port : PortW'($urandom_range(0, 31)), b,
              i == len - 1, draw_idle(mode), drain && i == 0);
      // Slip a table read into the middle of the frame now and then
      if (i != len - 1 && $urandom_range(0, 299) == 0)
        add_read(draw_idle(mode));
    end
  endtask

  // Driver: offer queued requests after their idle gap
  always @(posedge clk_i) begin
    logic ready_for_next;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      ready_for_next = !push;
      if (push && !full) begin
        apply_probe_request('{func: func_e'(func_i), port: port_i, data: data_byte_i,
                              eof: frame_end_i, idle: 0, drain: 1'b0});
        n_taken <= n_taken + 1;
        ready_for_next = 1'b1;
      end
      if (ready_for_next) begin
        if (!have_next && queued_requests.size() != 0) begin
          next_req  = queued_requests.pop_front();
          have_next = 1'b1;
          idle_left = next_req.idle;
        end
        if (have_next && idle_left > 0) begin
          idle_left--;
          push <= 1'b0;
        end else if (have_next && (!next_req.drain || pending_verdicts.size() == 0)) begin
          have_next   = 1'b0;
          push        <= 1'b1;
          func_i      <= next_req.func;
          port_i      <= next_req.port;
          data_byte_i <= next_req.data;
          frame_end_i <= next_req.eof;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: take verdicts, compare against the oldest expectation, then stall
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          n_fail++;
          if (n_fail <= 40)
            $display("%0t ns: unexpected result, expected none, actual sender %0h",
                     $time, sender_port_o);
        end else begin
          want = pending_verdicts.pop_front();
          check_field("probe_valid", ByteW'(want.probe_valid), ByteW'(probe_valid_o));
          check_field("sender_port", want.sender_port, sender_port_o);
          check_field("paired_port", want.paired_port, paired_port_o);
          check_field("newly_recorded", ByteW'(want.newly_recorded),
                      ByteW'(newly_recorded_o));
          check_field("port_out_of_range", ByteW'(want.port_out_of_range),
                      ByteW'(port_out_of_range_o));
        end
        n_seen <= n_seen + 1;
        stall_left = draw_idle((n_seen / 40) % 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= !rx_hold;
      end
    end
  end

  // Hold off the result side for a long stretch while reads keep coming
  initial begin
    @(posedge rst_ni);
    wait (n_taken >= burst_at);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Build the stimulus, release reset, then wait for the last verdict
  initial begin
    int mode;
    logic [ByteW-1:0] snd;

    foreach (pair_map[i]) pair_map[i] = EmptyEntry;

    // Reads of the table ends and out-of-range indexes, then tiny frames
    add_req(FuncRead, 5'd0, 8'h00, 1'b0, 0, 1'b0);
    add_req(FuncRead, 5'd25, 8'hFF, 1'b1, 0, 1'b0);
    add_req(FuncRead, 5'd26, 8'h00, 1'b1, 0, 1'b0);
    add_req(FuncRead, 5'd31, 8'hFF, 1'b0, 0, 1'b0);
    queue_frame(1, 8'h00, -1, 5'd31, 0, 1'b0);
    queue_frame(2, 8'h00, -1, 5'd0, 1, 1'b0);
    queue_frame(16, 8'h00, -1, 5'd17, 2, 1'b0);

    // Back-to-back reads to fill the block while results are held off
    burst_at = n_built;
    repeat (14) add_read(0);

    // A clean frame up to four bytes too long, sent once every earlier result is out
    snd  = ByteW'($urandom_range(0, PortCount - 1));
    mode = $urandom_range(0, 2);
    queue_frame(FrameBytes + $urandom_range(0, 4), snd, -1, PortW'($urandom_range(0, 31)),
                mode, 1'b1);
    add_req(FuncRead, snd[PortW-1:0], 8'h00, 1'b0, draw_idle(mode), 1'b0);

    // A frame that ends on its sender byte, with a sender beyond the table
    snd = ByteW'($urandom_range(PortCount, 255));
    queue_frame(SenderOffset + 1, snd, -1, PortW'($urandom_range(0, 31)), 2, 1'b0);
    repeat (6) add_read(draw_idle(1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_taken == n_built);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
